/* design/fpl_pkg.sv */
// Shared types, widths and reset values for the five-point Laplacian stream.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package fpl_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W     = 32;
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 13;
  localparam int INV_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CELL_X_W     = 8;
  localparam int CELL_Y_W     = 12;

  // Default patch limits.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Register reset values.
  localparam logic [CFG_WIDTH_W-1:0]  RST_PATCH_WIDTH  = 9'd8;
  localparam logic [CFG_HEIGHT_W-1:0] RST_PATCH_HEIGHT = 13'd8;
  localparam logic [INV_W-1:0]        RST_INV_SPACING  = 32'd65536;

  // Stencil window: one cell per padded column, three columns wide.
  localparam int NUM_CELLS = 3;

  // Arithmetic widths. The stencil sum needs two bits above a sample plus sign.
  localparam int SUM_W    = SAMPLE_W + 3;
  localparam int FRAC_W   = 16;
  localparam int LO_W     = 17;
  localparam int HI_W     = SUM_W - LO_W;
  localparam int PP_LO_W  = LO_W + INV_W;
  localparam int PP_HI_W  = HI_W + INV_W + 1;
  localparam int PROD_W   = PP_HI_W + LO_W;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATCH_WIDTH    = 2'd0,
    CFG_PATCH_HEIGHT   = 2'd1,
    CFG_INV_SPACING_SQ = 2'd2
  } cfg_idx_e;

  // One padded column of the stencil: row above, middle row, current row.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] down;
  } column_t;

  // Coordinates and end marker that travel with a result.
  typedef struct packed {
    logic                last;
    logic [CELL_X_W-1:0] x;
    logic [CELL_Y_W-1:0] y;
  } cell_tag_t;

  // Pipeline advance strobes handed to the scaler.
  typedef struct packed {
    logic load_sum;
    logic load_prod;
    logic load_out;
  } scale_ctrl_t;

endpackage

/* design/fpl_column_cell.sv */
// One window cell: holds a padded column of the stencil and passes it on.
// Depends on fpl_pkg for column_t and sample width.
`timescale 1ns / 1ps

module fpl_column_cell
  import fpl_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  column_t                   col_i,
  output column_t                   col_o,
  output logic signed [SAMPLE_W:0]  vert_o
);

  column_t col_q, col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // Vertical pair of this column, used when the cell sits at the centre.
  assign vert_o = (SAMPLE_W+1)'(col_q.up) + (SAMPLE_W+1)'(col_q.down);
  assign col_o  = col_q;

endmodule

/* design/fpl_line_buffer.sv */
// Raster counters and the two padded-row line stores of the stencil.
// Depends on fpl_pkg; each store is a one-write, one-read memory.
`timescale 1ns / 1ps

module fpl_line_buffer
  import fpl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     commit_i,
  input  logic [SAMPLE_W-1:0]      sample_i,
  input  logic [CFG_WIDTH_W-1:0]   cfg_width_i,
  input  logic [CFG_HEIGHT_W-1:0]  cfg_height_i,
  output column_t                  column_o,
  output logic                     emit_o,
  output cell_tag_t                tag_o
);

  localparam int DEPTH = MAX_WIDTH + 2;
  localparam int CW    = $clog2(MAX_WIDTH + 2);
  localparam int RW    = $clog2(MAX_HEIGHT + 3);
  localparam int WCMP  = (CFG_WIDTH_W > CW) ? CFG_WIDTH_W : CW;
  localparam int HCMP  = (CFG_HEIGHT_W > RW) ? CFG_HEIGHT_W : RW;

  logic [WCMP-1:0] w_ext, w_eff;
  logic [HCMP-1:0] h_ext, h_eff;
  logic [CW-1:0]   w_lim;
  logic [RW-1:0]   h_lim;

  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_pre, row_cur;

  logic [SAMPLE_W-1:0] store_up  [DEPTH];
  logic [SAMPLE_W-1:0] store_mid [DEPTH];
  logic [SAMPLE_W-1:0] rd_up_q, rd_mid_q, sample_q;
  logic [CW-1:0]       addr_q;
  logic                emit_q;
  cell_tag_t           tag_q, tag_d;

  // Out-of-range sizes are clamped: zero acts as one, large values as the maximum.
  always_comb begin
    w_ext = WCMP'(cfg_width_i);
    h_ext = HCMP'(cfg_height_i);
    w_eff = w_ext;
    h_eff = h_ext;
    if (w_ext == '0) begin
      w_eff = WCMP'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end
    if (h_ext == '0) begin
      h_eff = HCMP'(1);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end
    w_lim = CW'(w_eff) + CW'(1);
    h_lim = RW'(h_eff) + RW'(1);
  end

  // Position of the word being accepted, wrapping at once if the bounds shrank.
  always_comb begin
    col_cur = col_q;
    row_pre = row_q;
    if (col_q > w_lim) begin
      col_cur = '0;
      row_pre = row_q + RW'(1);
    end
    row_cur = (row_pre > h_lim) ? '0 : row_pre;

    if (col_cur >= w_lim) begin
      col_d = '0;
      row_d = (row_cur >= h_lim) ? '0 : row_cur + RW'(1);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end

    tag_d.x    = CELL_X_W'(col_cur - CW'(2));
    tag_d.y    = CELL_Y_W'(row_cur - RW'(2));
    tag_d.last = (col_cur == w_lim) && (row_cur == h_lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage registers of the accepted word; held until the window takes them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (accept_i) begin
      emit_q <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sample_q <= sample_i;
      addr_q   <= col_cur;
      tag_q    <= tag_d;
    end
  end

  // Middle store: the old entry is read out as the new sample replaces it.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_mid_q          <= store_mid[col_cur];
      store_mid[col_cur] <= sample_i;
    end
  end

  // Upper store: takes the old middle entry once it has been read out.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_up_q <= store_up[col_cur];
    end
    if (commit_i) begin
      store_up[addr_q] <= rd_mid_q;
    end
  end

  assign column_o.up   = rd_up_q;
  assign column_o.mid  = rd_mid_q;
  assign column_o.down = sample_q;
  assign emit_o        = emit_q;
  assign tag_o         = tag_q;

endmodule

/* design/fpl_scaler.sv */
// Scales the stencil sum by the reciprocal spacing, floors and saturates.
// Depends on fpl_pkg; three register stages split the wide multiply.
`timescale 1ns / 1ps

module fpl_scaler
  import fpl_pkg::*;
(
  input  logic                      clk_i,
  input  scale_ctrl_t               ctrl_i,
  input  logic signed [SUM_W-1:0]   sum_i,
  input  logic [INV_W-1:0]          inv_i,
  output logic [SAMPLE_W-1:0]       result_o
);

  logic signed [SUM_W-1:0]   sum_q;
  logic [LO_W-1:0]           lo;
  logic signed [HI_W-1:0]    hi;
  logic signed [INV_W:0]     inv_s;
  logic [PP_LO_W-1:0]        pp_lo_d, pp_lo_q;
  logic signed [PP_HI_W-1:0] pp_hi_d, pp_hi_q;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-FRAC_W-SAMPLE_W:0] top;
  logic [SAMPLE_W-1:0]       result_d, result_q;

  // Sum split into an unsigned low part and a signed high part.
  assign lo      = sum_q[LO_W-1:0];
  assign hi      = sum_q[SUM_W-1:LO_W];
  assign inv_s   = $signed({1'b0, inv_i});
  assign pp_lo_d = lo * inv_i;
  assign pp_hi_d = hi * inv_s;

  // Exact product; an arithmetic shift by the fraction width floors it.
  assign prod = {pp_hi_q, {LO_W{1'b0}}} + {{(PROD_W-PP_LO_W){1'b0}}, pp_lo_q};
  assign top  = prod[PROD_W-1:FRAC_W+SAMPLE_W-1];

  always_comb begin
    if ((&top) || !(|top)) begin
      result_d = prod[FRAC_W+SAMPLE_W-1:FRAC_W];
    end else begin
      result_d = prod[PROD_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      sum_q <= sum_i;
    end
    if (ctrl_i.load_prod) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
    if (ctrl_i.load_out) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

/* design/five_point_laplacian_stream_top.sv */
// Top level of the streaming five-point Laplacian: configuration registers,
// pipeline control, the window cell chain. Depends on fpl_pkg, fpl_line_buffer,
// fpl_column_cell and fpl_scaler.
`timescale 1ns / 1ps

// How to use this block:
// The input channel (in_valid_i / in_ready_o / sample_i) takes one signed Q16.16
// word per cycle while in_ready_o is high, in raster order over a patch padded
// by one ghost cell on each side, so (patch_width+2) by (patch_height+2) words
// make one patch. Patches follow one another without a gap.
// For every interior cell one result word leaves on the output channel
// (out_valid_o / out_ready_i) with the scaled Laplacian, its interior column
// and row, and last_cell_o high on the final cell of the patch. A cell's result
// is produced by the input word just below its right-hand neighbor; that word
// passes the line-store, window, sum, partial-product and output registers.
// Throughput is one word per cycle without stalls; the bound is the single write
// port of each line store, used once per word. Ghost words produce no output.
// When the receiver stalls, the pipeline fills its empty stages first and then
// deasserts in_ready_o; nothing is dropped and the output word holds.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
// cfg_data_i) is always ready; write it only while the stream is idle.
// Reset clears the counters, the window and all pipeline valids and loads the
// register defaults (8 by 8 cells, reciprocal 1.0). The line stores need no
// clearing: every entry that feeds a result is written before it is read.

module five_point_laplacian_stream_top
  import fpl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sample stream
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_W-1:0]    sample_i,
  // Result stream
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_W-1:0]    laplacian_o,
  output logic [CELL_X_W-1:0]    cell_x_o,
  output logic [CELL_Y_W-1:0]    cell_y_o,
  output logic                   last_cell_o,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [CFG_WIDTH_W-1:0]  patch_width_q;
  logic [CFG_HEIGHT_W-1:0] patch_height_q;
  logic [INV_W-1:0]        inv_spacing_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_width_q  <= RST_PATCH_WIDTH;
      patch_height_q <= RST_PATCH_HEIGHT;
      inv_spacing_q  <= RST_INV_SPACING;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PATCH_WIDTH:    patch_width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
        CFG_PATCH_HEIGHT:   patch_height_q <= cfg_data_i[CFG_HEIGHT_W-1:0];
        CFG_INV_SPACING_SQ: inv_spacing_q  <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline stages:
  //   1: line-store read of the accepted word (every word),
  //   2: window cells hold the stencil (result-bearing words only),
  //   3: stencil sum, 4: partial products, 5: output register.
  // Each stage moves when the stage after it is empty or moving too.
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic adv1, adv2, adv3, adv4, free2, free3, free4, free_o, accept;

  assign free_o = !vo_q || out_ready_i;
  assign adv4   = v4_q && free_o;
  assign free4  = !v4_q || adv4;
  assign adv3   = v3_q && free4;
  assign free3  = !v3_q || adv3;
  assign adv2   = v2_q && free3;
  assign free2  = !v2_q || adv2;
  assign adv1   = v1_q && free2;

  assign in_ready_o = !v1_q || adv1;
  assign accept     = in_valid_i && in_ready_o;

  column_t   lb_column;
  logic      lb_emit;
  cell_tag_t lb_tag;

  fpl_line_buffer #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line_buffer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .commit_i     (adv1),
    .sample_i     (sample_i),
    .cfg_width_i  (patch_width_q),
    .cfg_height_i (patch_height_q),
    .column_o     (lb_column),
    .emit_o       (lb_emit),
    .tag_o        (lb_tag)
  );

  // Window: cell 0 holds the newest column, cell 1 the centre, cell 2 the
  // oldest. Every word shifts the chain by one column, ghost words included.
  column_t                 cell_col  [NUM_CELLS];
  logic signed [SAMPLE_W:0] cell_vert [NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    column_t chain_in;
    if (i == 0) begin : g_head
      assign chain_in = lb_column;
    end else begin : g_link
      assign chain_in = cell_col[i-1];
    end
    fpl_column_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (adv1),
      .col_i   (chain_in),
      .col_o   (cell_col[i]),
      .vert_o  (cell_vert[i])
    );
  end

  // Up + down + left + right - 4 * centre.
  logic signed [SUM_W-1:0] stencil_sum;

  assign stencil_sum = SUM_W'(cell_vert[1])
                     + SUM_W'(cell_col[0].mid)
                     + SUM_W'(cell_col[2].mid)
                     - (SUM_W'(cell_col[1].mid) <<< 2);

  scale_ctrl_t         scale_ctrl;
  logic [SAMPLE_W-1:0] scaled;

  assign scale_ctrl.load_sum  = adv2;
  assign scale_ctrl.load_prod = adv3;
  assign scale_ctrl.load_out  = adv4;

  fpl_scaler u_scaler (
    .clk_i    (clk_i),
    .ctrl_i   (scale_ctrl),
    .sum_i    (stencil_sum),
    .inv_i    (inv_spacing_q),
    .result_o (scaled)
  );

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        v2_q <= lb_emit;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end
      if (adv2) begin
        v3_q <= 1'b1;
      end else if (adv3) begin
        v3_q <= 1'b0;
      end
      if (adv3) begin
        v4_q <= 1'b1;
      end else if (adv4) begin
        v4_q <= 1'b0;
      end
      if (adv4) begin
        vo_q <= 1'b1;
      end else if (out_ready_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  // Coordinates follow their sum down the pipeline.
  cell_tag_t tag2_q, tag3_q, tag4_q, tago_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      tag2_q <= lb_tag;
    end
    if (adv2) begin
      tag3_q <= tag2_q;
    end
    if (adv3) begin
      tag4_q <= tag3_q;
    end
    if (adv4) begin
      tago_q <= tag4_q;
    end
  end

  assign out_valid_o = vo_q;
  assign laplacian_o = scaled;
  assign cell_x_o    = tago_q.x;
  assign cell_y_o    = tago_q.y;
  assign last_cell_o = tago_q.last;

endmodule

/* test/tb.sv */
// Self-checking testbench for five_point_laplacian_stream_top: streams padded patches,
// predicts every interior-cell result and compares it with the block's output.
// Depends on fpl_pkg and the design files of the block; needs nothing else.
`timescale 1ns / 1ps

module tb;
  import fpl_pkg::*;

  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 4;
  // Extra edges at an idle point; covers the pipeline depth with margin.
  localparam int          DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_WORDS = 330;
  localparam int          STORE_DEPTH  = DEF_MAX_WIDTH + 2;

  // Register index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  localparam logic [SAMPLE_W-1:0] TOP_WORD    = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] BOTTOM_WORD = 32'h8000_0000;

  // Predicts the stencil results from the accepted words and checks the
  // block's result words against them in order.
  class laplacian_scoreboard;
    typedef struct packed {
      logic [SAMPLE_W-1:0] laplacian;
      logic [CELL_X_W-1:0] x;
      logic [CELL_Y_W-1:0] y;
      logic                last;
    } cell_result_t;

    logic [CFG_WIDTH_W-1:0]     patch_width;
    logic [CFG_HEIGHT_W-1:0]    patch_height;
    logic [INV_W-1:0]           inv_spacing_sq;
    logic signed [SAMPLE_W-1:0] upper_row [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] middle_row [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] window [3];
    logic signed [SAMPLE_W-1:0] upper_prev;
    logic signed [SAMPLE_W-1:0] sample_prev;
    int unsigned                col;
    int unsigned                row;
    cell_result_t               expected_cells[$];
    int                         errors;

    function new();
      patch_width    = RST_PATCH_WIDTH;
      patch_height   = RST_PATCH_HEIGHT;
      inv_spacing_sq = RST_INV_SPACING;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      upper_prev  = '0;
      sample_prev = '0;
      col         = 0;
      row         = 0;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_PATCH_WIDTH:    patch_width    = data[CFG_WIDTH_W-1:0];
        CFG_PATCH_HEIGHT:   patch_height   = data[CFG_HEIGHT_W-1:0];
        CFG_INV_SPACING_SQ: inv_spacing_sq = data[INV_W-1:0];
        default: ;
      endcase
    endfunction

    // A size of zero acts as one; sizes above the maximum are clamped.
    function int unsigned active_width();
      if (patch_width == 0) return 1;
      if (patch_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return patch_width;
    endfunction

    function int unsigned active_height();
      if (patch_height == 0) return 1;
      if (patch_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
      return patch_height;
    endfunction

    function int outstanding();
      return expected_cells.size();
    endfunction

    // The full product fits in 68 bits; an arithmetic shift rounds toward
    // minus infinity, and the value saturates unless bits 67..31 agree.
    function logic [SAMPLE_W-1:0] scale_saturate(logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W+INV_W:0] product;
      logic signed [SUM_W+INV_W:0] floored;
      product = sum * $signed({1'b0, inv_spacing_sq});
      floored = product >>> FRAC_W;
      if (&floored[SUM_W+INV_W:SAMPLE_W-1] || ~|floored[SUM_W+INV_W:SAMPLE_W-1])
        return floored[SAMPLE_W-1:0];
      return floored[SUM_W+INV_W] ? SAT_MIN : SAT_MAX;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] word);
      int unsigned                w;
      int unsigned                h;
      int unsigned                c;
      int unsigned                r;
      logic signed [SAMPLE_W-1:0] up_c;
      logic signed [SAMPLE_W-1:0] mid_c;
      logic signed [SUM_W-1:0]    sum;
      cell_result_t               entry;
      w = active_width();
      h = active_height();
      // Counters beyond a shrunken patch wrap at once.
      if (col > w + 1) begin
        col = 0;
        row++;
      end
      if (row > h + 1) row = 0;
      c = col;
      r = row;
      up_c  = upper_row[c];
      mid_c = middle_row[c];
      window[0] = window[1];
      window[1] = window[2];
      window[2] = mid_c;
      // The word below the right-hand neighbor completes the cell at (c-2, r-2).
      if (r >= 2 && c >= 2) begin
        sum = upper_prev + sample_prev + window[0] + window[2] - 4 * window[1];
        entry.laplacian = scale_saturate(sum);
        entry.x         = CELL_X_W'(c - 2);
        entry.y         = CELL_Y_W'(r - 2);
        entry.last      = (c == w + 1) && (r == h + 1);
        expected_cells.push_back(entry);
      end
      upper_prev    = up_c;
      sample_prev   = word;
      upper_row[c]  = mid_c;
      middle_row[c] = word;
      if (c >= w + 1) begin
        col = 0;
        row = (r >= h + 1) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] laplacian, logic [CELL_X_W-1:0] x,
                               logic [CELL_Y_W-1:0] y, logic last);
      cell_result_t entry;
      if (expected_cells.size() == 0) begin
        $error("result word with nothing expected: laplacian %h at (%0d, %0d)",
               laplacian, x, y);
        errors++;
        return;
      end
      entry = expected_cells.pop_front();
      if (laplacian !== entry.laplacian) begin
        $error("laplacian: expected %h, got %h", entry.laplacian, laplacian);
        errors++;
      end
      if (x !== entry.x) begin
        $error("cell_x: expected %0d, got %0d", entry.x, x);
        errors++;
      end
      if (y !== entry.y) begin
        $error("cell_y: expected %0d, got %0d", entry.y, y);
        errors++;
      end
      if (last !== entry.last) begin
        $error("last_cell: expected %0b, got %0b", entry.last, last);
        errors++;
      end
    endfunction
  endclass

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // Every input of the block starts at a known value.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [SAMPLE_W-1:0]   sample_i    = '0;
  logic                  out_ready_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [SAMPLE_W-1:0]   laplacian_o;
  logic [CELL_X_W-1:0]   cell_x_o;
  logic [CELL_Y_W-1:0]   cell_y_o;
  logic                  last_cell_o;
  logic                  cfg_ready_o;

  laplacian_scoreboard board;
  reg_write_t          register_writes[$];
  logic [SAMPLE_W-1:0] patch_words[$];
  int unsigned         cycle_count   = 0;
  int                  words_sent    = 0;
  // One-in-N odds that a word or a cycle starts an idle burst; zero means none.
  int                  tx_gap_odds   = 0;
  int                  rx_stall_odds = 0;
  // Set for the closing patches, where neither side idles.
  bit                  calm          = 1'b0;
  bit                  spare_pending = 1'b1;

  five_point_laplacian_stream_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .laplacian_o (laplacian_o),
    .cell_x_o    (cell_x_o),
    .cell_y_o    (cell_y_o),
    .last_cell_o (last_cell_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Run limit: far beyond the slowest legal run, so only a hang trips it.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: ready drops at random for idle bursts, except in the calm
  // closing stretch.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (!calm && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Every result word accepted at an edge is checked against the oldest
  // prediction. Signals are read before the edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(laplacian_o, cell_x_o, cell_y_o, last_cell_o);
  end

  // Mostly full-range and small signed values, with the two extremes often.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return TOP_WORD;
      1:       return BOTTOM_WORD;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Reciprocals: zero, all ones, unity, tiny ones that expose the rounding,
  // and ordinary ones.
  function automatic logic [INV_W-1:0] random_reciprocal();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return RST_INV_SPACING;
      3:       return $urandom_range(1, 255);
      4:       return $urandom();
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  // A 3 by 3 padded patch: one interior cell with its four arms and corners.
  function automatic void load_cross(logic [SAMPLE_W-1:0] corner, logic [SAMPLE_W-1:0] arm,
                                     logic [SAMPLE_W-1:0] centre);
    patch_words = '{corner, arm, corner, arm, centre, arm, corner, arm, corner};
  endfunction

  // Offers one word, after an optional idle burst, and holds it until taken.
  task automatic send_word(input logic [SAMPLE_W-1:0] word);
    if (!calm && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= word;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(word);
    words_sent++;
  endtask

  // Drops valid and waits until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
  endtask

  // Idle point: all results in, then enough edges for the pipeline to empty.
  task automatic settle();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sends one whole padded patch. With write_config the three registers are
  // written first while the block is idle, sometimes after throwaway writes
  // that put random bits on every data line. Words come from patch_words
  // while it holds any, and are random after that. With hold_mid the sender
  // stops halfway until every result so far has come back.
  task automatic run_patch(input bit write_config, input logic [CFG_DATA_W-1:0] width_data,
                           input logic [CFG_DATA_W-1:0] height_data,
                           input logic [CFG_DATA_W-1:0] inv_data, input bit hold_mid);
    int unsigned total;
    settle();
    if (write_config) begin
      if (spare_pending || $urandom_range(0, 2) == 0) begin
        register_writes.push_back('{idx: CFG_PATCH_WIDTH, data: $urandom()});
        register_writes.push_back('{idx: CFG_PATCH_HEIGHT, data: $urandom()});
      end
      if (spare_pending || $urandom_range(0, 5) == 0)
        register_writes.push_back('{idx: CFG_SPARE_IDX, data: $urandom()});
      spare_pending = 1'b0;
      register_writes.push_back('{idx: CFG_PATCH_WIDTH, data: width_data});
      register_writes.push_back('{idx: CFG_PATCH_HEIGHT, data: height_data});
      register_writes.push_back('{idx: CFG_INV_SPACING_SQ, data: inv_data});
      // Back-to-back writes keep cfg_valid_i high between them.
      while (register_writes.size() != 0) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= register_writes[0].idx;
        cfg_data_i  <= register_writes[0].data;
        do @(posedge clk_i); while (!cfg_ready_o);
        board.write_register(register_writes[0].idx, register_writes[0].data);
        void'(register_writes.pop_front());
      end
      cfg_valid_i <= 1'b0;
    end
    total = (board.active_width() + 2) * (board.active_height() + 2);
    for (int unsigned n = 0; n < total; n++) begin
      if (hold_mid && n == total / 2) wait_for_results();
      send_word(patch_words.size() != 0 ? patch_words.pop_front() : random_sample());
    end
  endtask

  initial begin : stimulus
    int target;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first patch runs on the reset values of all three registers.
    tx_gap_odds   = 4;
    rx_stall_odds = 4;
    run_patch(1'b0, '0, '0, '0, 1'b0);

    // Directed single-cell patches. Arms at the top and the centre at the
    // bottom overflow upward; the mirror image with the largest reciprocal
    // overflows downward; a zero reciprocal zeroes a nonzero sum.
    load_cross('0, TOP_WORD, BOTTOM_WORD);
    run_patch(1'b1, 1, 1, RST_INV_SPACING, 1'b0);
    load_cross('0, BOTTOM_WORD, TOP_WORD);
    run_patch(1'b1, 1, 1, '1, 1'b0);
    load_cross(BOTTOM_WORD, 32'hFFFF_FFFF, 32'h0001_0000);
    run_patch(1'b1, 1, 1, '0, 1'b0);

    // Size corner cases: a wider patch with the sender pausing halfway until
    // the block has emptied, a zero width that acts as one column, and a
    // zero height that acts as one row.
    run_patch(1'b1, 16, 2, RST_INV_SPACING, 1'b1);
    run_patch(1'b1, 0, 3, random_reciprocal(), 1'b0);
    run_patch(1'b1, 1, 0, random_reciprocal(), 1'b0);

    // Random patches, mostly small, with idling switched on and off per patch.
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      tx_gap_odds   = $urandom_range(0, 1) ? $urandom_range(3, 8) : 0;
      rx_stall_odds = $urandom_range(0, 1) ? $urandom_range(3, 8) : 0;
      run_patch(1'b1,
                ($urandom_range(0, 3) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10),
                $urandom_range(0, 5), random_reciprocal(), 1'b0);
    end

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    repeat (2) run_patch(1'b1, $urandom_range(1, 12), $urandom_range(1, 4),
                         random_reciprocal(), 1'b0);

    settle();
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
